@@ hw/rtl/tef_pkg.sv @@
// shared types and constants for the terminal escape filter
package tef_pkg;

  localparam int unsigned CHANNELS = 1024;
  localparam int unsigned CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // parser states, one-hot, as held in the state memory
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ESC   = 6'b000010,
    ST_OSC   = 6'b000100,
    ST_CSI   = 6'b001000,
    ST_STR   = 6'b010000,
    ST_INTER = 6'b100000
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    logic    saw_esc;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_IDLE = '{st: ST_IDLE, saw_esc: 1'b0};

  // item function codes
  localparam logic FN_FILTER = 1'b0;
  localparam logic FN_RESET  = 1'b1;

  // state clearing sweep status
  typedef struct packed {
    logic             active;
    logic             we;
    logic [CH_AW-1:0] addr;
  } clr_t;

  // byte codes
  localparam logic [7:0] C_BEL   = 8'h07;
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LF    = 8'h0a;
  localparam logic [7:0] C_CR    = 8'h0d;
  localparam logic [7:0] C_ESC   = 8'h1b;
  localparam logic [7:0] C_SP    = 8'h20;
  localparam logic [7:0] C_SLASH = 8'h2f;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_AT    = 8'h40;
  localparam logic [7:0] C_DCS   = 8'h50;
  localparam logic [7:0] C_SOS   = 8'h58;
  localparam logic [7:0] C_LBR   = 8'h5b;
  localparam logic [7:0] C_BSL   = 8'h5c;
  localparam logic [7:0] C_RBR   = 8'h5d;
  localparam logic [7:0] C_PM    = 8'h5e;
  localparam logic [7:0] C_APC   = 8'h5f;
  localparam logic [7:0] C_TILDE = 8'h7e;
  localparam logic [7:0] C_DEL   = 8'h7f;

endpackage

@@ hw/rtl/tef_ram.sv @@
// generic single-port-write ram with registered read
module tef_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tef_clear.sv @@
// sweep that writes every state entry back to idle after reset
module tef_clear (
  input  logic          clk,
  input  logic          rst_n,
  output tef_pkg::clr_t clr
);

  logic                      active_r;
  logic                      active_nxt;
  logic [tef_pkg::CH_AW-1:0] addr_r;
  logic [tef_pkg::CH_AW-1:0] addr_nxt;

  always_comb begin
    active_nxt = active_r;
    addr_nxt   = addr_r;
    if (active_r) begin
      if (addr_r == tef_pkg::CH_AW'(tef_pkg::CHANNELS - 1)) begin
        active_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      addr_r   <= '0;
    end else begin
      active_r <= active_nxt;
      addr_r   <= addr_nxt;
    end
  end

  assign clr.active = active_r;
  assign clr.we     = active_r;
  assign clr.addr   = addr_r;

endmodule

@@ hw/rtl/tef_step.sv @@
// per-byte escape parser: next channel state and keep decision
module tef_step (
  input  tef_pkg::entry_t cur,
  input  logic [7:0]      data_byte,
  output tef_pkg::entry_t nxt,
  output logic            keep
);

  logic is_esc;
  logic lo_ok;

  assign is_esc = (data_byte == tef_pkg::C_ESC);

  always_comb begin
    nxt   = cur;
    keep  = 1'b0;
    lo_ok = 1'b0;
    unique case (cur.st)
      tef_pkg::ST_OSC, tef_pkg::ST_STR: begin
        if (cur.st == tef_pkg::ST_OSC && data_byte == tef_pkg::C_BEL) begin
          nxt = tef_pkg::ENTRY_IDLE;
        end else if (cur.saw_esc && data_byte == tef_pkg::C_BSL) begin
          nxt = tef_pkg::ENTRY_IDLE;
        end else begin
          nxt.saw_esc = is_esc;
        end
      end
      tef_pkg::ST_ESC: begin
        if (data_byte == tef_pkg::C_LBR) begin
          nxt.st = tef_pkg::ST_CSI;
        end else if (data_byte == tef_pkg::C_RBR) begin
          nxt.st      = tef_pkg::ST_OSC;
          nxt.saw_esc = 1'b0;
        end else if (data_byte == tef_pkg::C_DCS || data_byte == tef_pkg::C_SOS ||
                     data_byte == tef_pkg::C_PM  || data_byte == tef_pkg::C_APC) begin
          nxt.st      = tef_pkg::ST_STR;
          nxt.saw_esc = 1'b0;
        end else if (data_byte >= tef_pkg::C_SP && data_byte <= tef_pkg::C_SLASH) begin
          nxt.st = tef_pkg::ST_INTER;
        end else begin
          nxt.st = tef_pkg::ST_IDLE;
        end
      end
      tef_pkg::ST_CSI, tef_pkg::ST_INTER: begin
        // final byte range starts lower for intermediate sequences
        lo_ok = (cur.st == tef_pkg::ST_CSI) ? (data_byte >= tef_pkg::C_AT)
                                            : (data_byte >= tef_pkg::C_ZERO);
        if (is_esc) begin
          nxt.st = tef_pkg::ST_ESC;
        end else if (lo_ok && data_byte <= tef_pkg::C_TILDE) begin
          nxt.st = tef_pkg::ST_IDLE;
        end
      end
      default: begin
        nxt.st = tef_pkg::ST_IDLE;
        if (is_esc) begin
          nxt.st = tef_pkg::ST_ESC;
        end else if (data_byte == tef_pkg::C_DEL ||
                     (data_byte < tef_pkg::C_SP && data_byte != tef_pkg::C_LF &&
                      data_byte != tef_pkg::C_TAB && data_byte != tef_pkg::C_CR)) begin
          keep = 1'b0;
        end else begin
          keep = 1'b1;
        end
      end
    endcase
  end

endmodule

@@ hw/rtl/terminal_escape_filter.sv @@
// terminal escape filter top level: per-channel escape stripping over a state memory
// pipeline: an accepted transaction passes through stage 1, then the output register, on to out_
// throughput: one byte per cycle, any channel mix, unless out_ready stalls; one memory read and one write per cycle
// reset: synchronous rst_n starts a clearing sweep over all CHANNELS (1024) entries that sets
// every channel to idle; in_ready stays low until the sweep is done
module terminal_escape_filter (
  input  logic       clk,
  input  logic       rst_n,
  // input transactions
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [9:0] in_channel,
  input  logic [7:0] in_data_byte,
  input  logic       in_chunk_end,
  // result transactions
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] out_channel,
  output logic [7:0] out_clean_byte,
  output logic       out_keep,
  output logic       out_chunk_end
);

  // clearing sweep after reset
  tef_pkg::clr_t clr;

  // accept side: address decode
  logic                      in_acc;
  logic [31:0]               ch_ext;
  logic                      in_inrange;
  logic [tef_pkg::CH_AW-1:0] raddr;

  // memory write port
  logic                        mem_we;
  logic [tef_pkg::CH_AW-1:0]   mem_waddr;
  tef_pkg::entry_t             mem_wdata;
  logic [tef_pkg::ENTRY_W-1:0] mem_rdata;
  logic                        fwd_hit;

  // stage 1: memory data arrives, state is updated and written back
  logic                      s1_valid_r;
  logic                      s1_func_r;
  logic                      s1_inr_r;
  logic [tef_pkg::CH_AW-1:0] s1_addr_r;
  logic [9:0]                s1_ch_r;
  logic [7:0]                s1_byte_r;
  logic                      s1_ce_r;
  logic                      s1_fwd_r;
  tef_pkg::entry_t           s1_fwd_d_r;
  logic                      s1_adv;

  tef_pkg::entry_t cur;
  tef_pkg::entry_t nxt;
  logic            step_keep;
  logic            keep;

  // output register
  logic       out_valid_r;
  logic [9:0] out_ch_r;
  logic [7:0] out_byte_r;
  logic       out_keep_r;
  logic       out_ce_r;

  tef_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  // stage 1 moves on whenever the output register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr.active && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  // channels past the configured count touch no state
  assign ch_ext     = 32'(in_channel);
  assign in_inrange = (ch_ext < tef_pkg::CHANNELS);
  assign raddr      = ch_ext[tef_pkg::CH_AW-1:0];

  // write port: sweep has the memory to itself, otherwise stage 1 writes back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr_r;
    mem_wdata = nxt;
    if (clr.active) begin
      mem_we    = clr.we;
      mem_waddr = clr.addr;
      mem_wdata = tef_pkg::ENTRY_IDLE;
    end else if (s1_adv && s1_inr_r) begin
      mem_we = 1'b1;
      if (s1_func_r == tef_pkg::FN_RESET) begin
        mem_wdata = tef_pkg::ENTRY_IDLE;
      end
    end
  end

  tef_ram #(
    .WIDTH (tef_pkg::ENTRY_W),
    .DEPTH (tef_pkg::CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  // the ram returns old data when read and written at one address in the same
  // cycle, so the write is captured alongside the new transaction and used instead
  assign fwd_hit = mem_we && (mem_waddr == raddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_func;
      s1_inr_r   <= in_inrange;
      s1_addr_r  <= raddr;
      s1_ch_r    <= in_channel;
      s1_byte_r  <= in_data_byte;
      s1_ce_r    <= in_chunk_end;
      s1_fwd_r   <= fwd_hit;
      s1_fwd_d_r <= mem_wdata;
    end
  end

  // current channel state, memory data or the bypassed write
  assign cur = s1_fwd_r ? s1_fwd_d_r : tef_pkg::entry_t'(mem_rdata);

  tef_step u_step (
    .cur       (cur),
    .data_byte (s1_byte_r),
    .nxt       (nxt),
    .keep      (step_keep)
  );

  // reset transactions and out-of-range channels never forward their byte
  assign keep = step_keep && s1_inr_r && (s1_func_r == tef_pkg::FN_FILTER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch_r   <= s1_ch_r;
      out_byte_r <= keep ? s1_byte_r : 8'h00;
      out_keep_r <= keep;
      out_ce_r   <= s1_ce_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_ch_r;
  assign out_clean_byte = out_byte_r;
  assign out_keep       = out_keep_r;
  assign out_chunk_end  = out_ce_r;

  // no transaction is taken while the sweep still owns the memory
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.active |-> !in_ready)
    else $error("transaction accepted during state clearing");

  // stage 1 write-back never collides with the sweep
  a_no_wb_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.active |-> !s1_valid_r)
    else $error("stage 1 busy during state clearing");

  // a stalled stage 1 keeps its transaction and address for the bypass to stay correct
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_addr_r) && $stable(s1_fwd_r)))
    else $error("stage 1 lost a stalled transaction");

  // dropped bytes leave the output byte at zero
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_keep) |-> (out_clean_byte == 8'h00))
    else $error("dropped byte not zeroed");

endmodule

@@ tb/tb_terminal_escape_filter.sv @@
// self-checking testbench for the per-channel terminal escape filter
module tb_terminal_escape_filter;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int unsigned PHASE_ITEMS  = 240;     // five random phases, about 1200 items
  localparam int unsigned HOLD_CYCLES  = 300;     // long receiver hold-off in the pressure phase
  localparam int unsigned DRAIN_CYCLES = 8;       // pipeline is two deep, allow some slack
  localparam int unsigned CYCLE_LIMIT  = 100000;  // watchdog bound on the whole run
  localparam int unsigned SLOTS        = 4;       // streams interleaved by the random part
  localparam int unsigned SLOT_DEPTH   = 16;
  localparam logic [8:0]  RESET_MARK   = 9'h100;  // bit 8 flags a parser reset transaction
  localparam logic        TYPED        = 1'b1;    // expectation written into the table
  localparam logic        PREDICTED    = 1'b0;    // expectation taken from the predictor

  typedef enum logic [2:0] {
    PH_STEADY,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH,
    PH_HOLD
  } phase_t;

  typedef struct packed {
    logic [9:0] chan;
    logic [7:0] clean;
    logic       keep;
    logic       flush;
  } result_t;

  typedef struct packed {
    logic       fn;
    logic [9:0] ch;
    logic [7:0] c;
    logic       last;
    logic       how;
    logic       keep;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_func;
  logic [9:0] in_channel;
  logic [7:0] in_data_byte;
  logic       in_chunk_end;
  logic       out_valid;
  logic       out_ready;
  logic [9:0] out_channel;
  logic [7:0] out_clean_byte;
  logic       out_keep;
  logic       out_chunk_end;

  // predictor copy of the per-channel parser memory
  tef_pkg::pstate_t chan_state [tef_pkg::CHANNELS];
  logic             chan_saw_esc [tef_pkg::CHANNELS];
  result_t          expected_results [$];
  result_t          oldest;
  int unsigned      errors;
  int unsigned      cycles;
  phase_t           phase;
  bit               hold_done;

  // interleaved random streams, one escape fragment at a time per slot
  logic [9:0] slot_ch [SLOTS];
  logic [8:0] slot_buf [SLOTS][SLOT_DEPTH];
  int         slot_len [SLOTS];
  int         slot_pos [SLOTS];

  // directed table: extremes, csi, osc, dcs and intermediate escapes and the string corner cases
  row_t directed_rows [25] = '{
    '{tef_pkg::FN_FILTER, 10'd0,    8'h41,          1'b1, TYPED,     1'b1},  // plain text
    '{tef_pkg::FN_FILTER, 10'd1023, 8'hff,          1'b0, TYPED,     1'b1},  // top chan, byte
    '{tef_pkg::FN_FILTER, 10'd5,    8'h00,          1'b0, TYPED,     1'b0},  // nul dropped
    '{tef_pkg::FN_FILTER, 10'd5,    tef_pkg::C_DEL, 1'b1, TYPED,     1'b0},  // delete dropped
    '{tef_pkg::FN_FILTER, 10'd5,    tef_pkg::C_TAB, 1'b0, TYPED,     1'b1},
    '{tef_pkg::FN_FILTER, 10'd5,    tef_pkg::C_LF,  1'b0, TYPED,     1'b1},
    '{tef_pkg::FN_FILTER, 10'd5,    tef_pkg::C_CR,  1'b0, TYPED,     1'b1},
    '{tef_pkg::FN_FILTER, 10'd5,    8'h1f,          1'b0, TYPED,     1'b0},  // last control
    '{tef_pkg::FN_FILTER, 10'd3,    tef_pkg::C_ESC, 1'b0, PREDICTED, 1'b0},  // csi opener
    '{tef_pkg::FN_FILTER, 10'd3,    tef_pkg::C_LBR, 1'b0, PREDICTED, 1'b0},
    '{tef_pkg::FN_FILTER, 10'd3,    tef_pkg::C_ESC, 1'b0, PREDICTED, 1'b0},  // restart in csi
    '{tef_pkg::FN_FILTER, 10'd3,    tef_pkg::C_RBR, 1'b0, PREDICTED, 1'b0},  // osc string
    '{tef_pkg::FN_FILTER, 10'd3,    8'h78,          1'b0, PREDICTED, 1'b0},
    '{tef_pkg::FN_FILTER, 10'd3,    tef_pkg::C_BEL, 1'b1, PREDICTED, 1'b0},  // bell ends osc
    '{tef_pkg::FN_FILTER, 10'd4,    tef_pkg::C_ESC, 1'b0, PREDICTED, 1'b0},
    '{tef_pkg::FN_FILTER, 10'd4,    tef_pkg::C_DCS, 1'b0, PREDICTED, 1'b0},  // dcs string
    '{tef_pkg::FN_FILTER, 10'd4,    tef_pkg::C_BEL, 1'b0, PREDICTED, 1'b0},  // bell stays
    '{tef_pkg::FN_FILTER, 10'd4,    tef_pkg::C_ESC, 1'b0, PREDICTED, 1'b0},
    '{tef_pkg::FN_FILTER, 10'd4,    8'h71,          1'b0, PREDICTED, 1'b0},  // lone escape
    '{tef_pkg::FN_FILTER, 10'd4,    tef_pkg::C_ESC, 1'b0, PREDICTED, 1'b0},
    '{tef_pkg::FN_FILTER, 10'd4,    tef_pkg::C_BSL, 1'b1, PREDICTED, 1'b0},  // terminator
    '{tef_pkg::FN_FILTER, 10'd6,    tef_pkg::C_ESC, 1'b0, PREDICTED, 1'b0},
    '{tef_pkg::FN_FILTER, 10'd6,    8'h28,          1'b0, PREDICTED, 1'b0},  // intermediate
    '{tef_pkg::FN_RESET,  10'd6,    8'h42,          1'b0, TYPED,     1'b0},  // parser reset
    '{tef_pkg::FN_FILTER, 10'd6,    8'h42,          1'b1, TYPED,     1'b1}   // idle, kept
  };

  terminal_escape_filter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_channel    (in_channel),
    .in_data_byte  (in_data_byte),
    .in_chunk_end  (in_chunk_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_clean_byte(out_clean_byte),
    .out_keep      (out_keep),
    .out_chunk_end (out_chunk_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // escape parser of one channel; updates the predictor state and returns the result
  function automatic result_t predict_filter(input logic fn, input logic [9:0] ch,
                                             input logic [7:0] c, input logic last);
    result_t          r;
    tef_pkg::pstate_t st;
    logic             esc;
    logic [7:0]       lo;
    logic             keep;
    keep = 1'b0;
    if (ch < tef_pkg::CHANNELS) begin
      if (fn == tef_pkg::FN_RESET) begin
        chan_state[ch]   = tef_pkg::ST_IDLE;
        chan_saw_esc[ch] = 1'b0;
      end else begin
        st  = chan_state[ch];
        esc = chan_saw_esc[ch];
        case (st)
          tef_pkg::ST_OSC, tef_pkg::ST_STR: begin
            // only bell (osc alone) or escape backslash closes a string
            if (c == tef_pkg::C_BEL && st == tef_pkg::ST_OSC) begin
              st  = tef_pkg::ST_IDLE;
              esc = 1'b0;
            end else if (esc && c == tef_pkg::C_BSL) begin
              st  = tef_pkg::ST_IDLE;
              esc = 1'b0;
            end else begin
              esc = (c == tef_pkg::C_ESC);
            end
          end
          tef_pkg::ST_ESC: begin
            if (c == tef_pkg::C_LBR) begin
              st = tef_pkg::ST_CSI;
            end else if (c == tef_pkg::C_RBR) begin
              st  = tef_pkg::ST_OSC;
              esc = 1'b0;
            end else if (c == tef_pkg::C_DCS || c == tef_pkg::C_SOS ||
                         c == tef_pkg::C_PM  || c == tef_pkg::C_APC) begin
              st  = tef_pkg::ST_STR;
              esc = 1'b0;
            end else if (c >= tef_pkg::C_SP && c <= tef_pkg::C_SLASH) begin
              st = tef_pkg::ST_INTER;
            end else begin
              st = tef_pkg::ST_IDLE;
            end
          end
          tef_pkg::ST_CSI, tef_pkg::ST_INTER: begin
            // final byte range is wider for intermediate sequences
            lo = (st == tef_pkg::ST_CSI) ? tef_pkg::C_AT : tef_pkg::C_ZERO;
            if (c == tef_pkg::C_ESC) st = tef_pkg::ST_ESC;
            else if (c >= lo && c <= tef_pkg::C_TILDE) st = tef_pkg::ST_IDLE;
          end
          default: begin
            st = tef_pkg::ST_IDLE;
            if (c == tef_pkg::C_ESC) st = tef_pkg::ST_ESC;
            else keep = !(c == tef_pkg::C_DEL ||
                          (c < tef_pkg::C_SP && c != tef_pkg::C_LF &&
                           c != tef_pkg::C_TAB && c != tef_pkg::C_CR));
          end
        endcase
        chan_state[ch]   = st;
        chan_saw_esc[ch] = esc;
      end
    end
    r.chan  = ch;
    r.clean = keep ? c : 8'h00;
    r.keep  = keep;
    r.flush = last;
    return r;
  endfunction

  function automatic int unsigned src_idle_pct();
    case (phase)
      PH_SRC_IDLE: return 68;
      PH_BOTH:     return 6;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct();
    case (phase)
      PH_SINK_STALL: return 68;
      PH_BOTH:       return 6;
      default:       return 0;
    endcase
  endfunction

  // offer one transaction, hold it until accepted, then log what should come out
  task automatic send_item(input logic fn, input logic [9:0] ch, input logic [7:0] c,
                           input logic last, input logic how, input logic tkeep);
    result_t r;
    while (roll(src_idle_pct())) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_channel   <= ch;
    in_data_byte <= c;
    in_chunk_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_filter(fn, ch, c, last);
    if (how == TYPED) begin
      r.keep  = tkeep;
      r.clean = tkeep ? c : 8'h00;
    end
    expected_results.push_back(r);
  endtask

  task automatic put(input int s, input logic [8:0] v);
    if (slot_len[s] < SLOT_DEPTH) begin
      slot_buf[s][slot_len[s]] = v;
      slot_len[s]++;
    end
  endtask

  // next fragment for a slot: mostly well-formed sequences, some noise
  task automatic refill(input int s);
    int unsigned kind;
    slot_len[s] = 0;
    slot_pos[s] = 0;
    if (roll(30))
      slot_ch[s] = roll(50) ? 10'($urandom_range(7, 0)) : 10'($urandom_range(1023, 0));
    kind = $urandom_range(9, 0);
    case (kind)
      0, 1: begin
        // printable text and utf-8 bytes
        repeat ($urandom_range(6, 1))
          put(s, roll(50) ? 9'($urandom_range(8'h7e, 8'h20)) : 9'($urandom_range(8'hff, 8'h80)));
      end
      2: begin
        put(s, {1'b0, tef_pkg::C_ESC});
        put(s, {1'b0, tef_pkg::C_LBR});
        repeat ($urandom_range(4, 0)) put(s, 9'($urandom_range(8'h3f, 8'h20)));
        put(s, 9'($urandom_range(8'h7e, 8'h40)));
      end
      3: begin
        put(s, {1'b0, tef_pkg::C_ESC});
        put(s, {1'b0, tef_pkg::C_RBR});
        repeat ($urandom_range(5, 0)) put(s, 9'($urandom_range(8'hff, 8'h20)));
        if (roll(50)) begin
          put(s, {1'b0, tef_pkg::C_BEL});
        end else begin
          put(s, {1'b0, tef_pkg::C_ESC});
          put(s, {1'b0, tef_pkg::C_BSL});
        end
      end
      4: begin
        put(s, {1'b0, tef_pkg::C_ESC});
        case ($urandom_range(3, 0))
          0:       put(s, {1'b0, tef_pkg::C_DCS});
          1:       put(s, {1'b0, tef_pkg::C_SOS});
          2:       put(s, {1'b0, tef_pkg::C_PM});
          default: put(s, {1'b0, tef_pkg::C_APC});
        endcase
        repeat ($urandom_range(4, 0)) begin
          if (roll(25)) begin
            // escape not followed by backslash keeps the string open
            put(s, {1'b0, tef_pkg::C_ESC});
            put(s, 9'($urandom_range(8'h5b, 8'h20)));
          end else begin
            put(s, roll(15) ? {1'b0, tef_pkg::C_BEL} : 9'($urandom_range(8'hff, 8'h20)));
          end
        end
        put(s, {1'b0, tef_pkg::C_ESC});
        put(s, {1'b0, tef_pkg::C_BSL});
      end
      5: begin
        put(s, {1'b0, tef_pkg::C_ESC});
        repeat ($urandom_range(2, 1)) put(s, 9'($urandom_range(8'h2f, 8'h20)));
        put(s, 9'($urandom_range(8'h7e, 8'h30)));
      end
      6: begin
        put(s, {1'b0, tef_pkg::C_ESC});
        put(s, 9'($urandom_range(8'h7e, 8'h30)));
      end
      7: begin
        repeat ($urandom_range(3, 1))
          put(s, roll(80) ? 9'($urandom_range(8'h1f, 8'h00)) : {1'b0, tef_pkg::C_DEL});
      end
      8: begin
        repeat ($urandom_range(4, 1)) put(s, 9'($urandom_range(8'hff, 8'h00)));
      end
      default: put(s, RESET_MARK);
    endcase
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls per phase, one long hold-off in the pressure phase
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_HOLD && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= !roll(sink_stall_pct());
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got ch %0h byte %0h keep %0b",
                 $realtime, out_channel, out_clean_byte, out_keep);
        errors++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("out_channel", oldest.chan, out_channel);
        check_field("out_clean_byte", oldest.clean, out_clean_byte);
        check_field("out_keep", oldest.keep, out_keep);
        check_field("out_chunk_end", oldest.flush, out_chunk_end);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int         s;
    logic [8:0] v;
    errors    = 0;
    cycles    = 0;
    hold_done = 1'b0;
    phase     = PH_STEADY;
    for (int i = 0; i < tef_pkg::CHANNELS; i++) begin
      chan_state[i]   = tef_pkg::ST_IDLE;
      chan_saw_esc[i] = 1'b0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      slot_ch[i]  = 10'($urandom_range(7, 0));
      slot_len[i] = 0;
      slot_pos[i] = 0;
    end
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_func      <= tef_pkg::FN_FILTER;
    in_channel   <= '0;
    in_data_byte <= '0;
    in_chunk_end <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, no idling; the first waits out the clearing sweep on in_ready
    foreach (directed_rows[i])
      send_item(directed_rows[i].fn, directed_rows[i].ch, directed_rows[i].c,
                directed_rows[i].last, directed_rows[i].how, directed_rows[i].keep);

    // random phases over interleaved streams
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       phase = PH_STEADY;
        1:       phase = PH_SRC_IDLE;
        2:       phase = PH_SINK_STALL;
        3:       phase = PH_BOTH;
        default: phase = PH_HOLD;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s = $urandom_range(SLOTS - 1, 0);
        if (slot_pos[s] >= slot_len[s]) refill(s);
        v = slot_buf[s][slot_pos[s]];
        slot_pos[s]++;
        send_item(v[8] ? tef_pkg::FN_RESET : tef_pkg::FN_FILTER, slot_ch[s],
                  v[8] ? 8'($urandom_range(255, 0)) : v[7:0],
                  logic'(roll(25)), PREDICTED, 1'b0);
      end
    end

    // drain with the receiver always ready
    phase = PH_STEADY;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
